[design/thw_pkg.sv]
`default_nettype none
package thw_pkg;

   localparam int CNT_W       = 32;
   localparam int TIME_W      = 48;
   localparam int ACC_W       = 48;
   localparam int TRIG_STAGES = 24;
   localparam int DIV_STEPS   = 64;

   localparam logic [31:0] INV_GAIN     = 32'h9B74EDA8;
   localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
   localparam logic [31:0] TWO_PI_E6_Q8 = 32'd1608495439;
   localparam logic [31:0] VEL_SCALE    = 32'd1000000;

   localparam logic [31:0] MPT_RESET    = 32'd122873;
   localparam logic [31:0] TPM_RESET    = 32'd18466200;
   localparam logic [31:0] OFFSET_RESET = 32'd1056965;

   localparam logic [2:0] REG_MPT_RIGHT = 3'd0;
   localparam logic [2:0] REG_MPT_LEFT  = 3'd1;
   localparam logic [2:0] REG_MPT_SIDE  = 3'd2;
   localparam logic [2:0] REG_TPM       = 3'd3;
   localparam logic [2:0] REG_OFFSET    = 3'd4;

   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_MLO  = 4'd2;
   localparam logic [3:0] OP_MHI  = 4'd3;
   localparam logic [3:0] OP_MWB  = 4'd4;
   localparam logic [3:0] OP_ROT  = 4'd5;
   localparam logic [3:0] OP_CORD = 4'd6;
   localparam logic [3:0] OP_ACC  = 4'd7;
   localparam logic [3:0] OP_DIVI = 4'd8;
   localparam logic [3:0] OP_DIVS = 4'd9;
   localparam logic [3:0] OP_DIVW = 4'd10;
   localparam logic [3:0] OP_OUT  = 4'd11;

   localparam logic [3:0] MUL_D0   = 4'd0;
   localparam logic [3:0] MUL_D1   = 4'd1;
   localparam logic [3:0] MUL_D2   = 4'd2;
   localparam logic [3:0] MUL_TURN = 4'd3;
   localparam logic [3:0] MUL_T2   = 4'd4;
   localparam logic [3:0] MUL_CORR = 4'd5;
   localparam logic [3:0] MUL_PX   = 4'd6;
   localparam logic [3:0] MUL_PY   = 4'd7;
   localparam logic [3:0] MUL_VX   = 4'd8;
   localparam logic [3:0] MUL_VY   = 4'd9;
   localparam logic [3:0] MUL_VT   = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] mid;
      logic [4:0] iter;
   } thw_cmd_type;

   typedef struct packed {
      logic started;
      logic dt_gt1;
      logic out_free;
   } thw_stat_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[design/thw_ctrl.sv]
`default_nettype none
module thw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire thw_pkg::thw_stat_type stat,
   output thw_pkg::thw_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MLO  = 4'd1;
   localparam logic [3:0] S_MHI  = 4'd2;
   localparam logic [3:0] S_MWB  = 4'd3;
   localparam logic [3:0] S_ROT  = 4'd4;
   localparam logic [3:0] S_CORD = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_DIVI = 4'd7;
   localparam logic [3:0] S_DIVS = 4'd8;
   localparam logic [3:0] S_DIVW = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [3:0] mid_ff, mid_in;
   logic [5:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mid_ff   <= thw_pkg::MUL_D0;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         mid_ff   <= mid_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      mid_in   = mid_ff;
      cnt_in   = cnt_ff;
      cmd.op   = thw_pkg::OP_NONE;
      cmd.mid  = mid_ff;
      cmd.iter = cnt_ff[4:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = thw_pkg::OP_LOAD;
               if (stat.started) begin
                  state_in = S_MLO;
                  mid_in   = thw_pkg::MUL_D0;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_MLO: begin
            cmd.op   = thw_pkg::OP_MLO;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.op   = thw_pkg::OP_MHI;
            state_in = S_MWB;
         end
         S_MWB: begin
            cmd.op = thw_pkg::OP_MWB;
            case (mid_ff)
               thw_pkg::MUL_D0: begin
                  mid_in = thw_pkg::MUL_D1; state_in = S_MLO;
               end
               thw_pkg::MUL_D1: begin
                  mid_in = thw_pkg::MUL_D2; state_in = S_MLO;
               end
               thw_pkg::MUL_D2: begin
                  mid_in = thw_pkg::MUL_TURN; state_in = S_MLO;
               end
               thw_pkg::MUL_TURN: begin
                  mid_in = thw_pkg::MUL_T2; state_in = S_MLO;
               end
               thw_pkg::MUL_T2: begin
                  mid_in = thw_pkg::MUL_CORR; state_in = S_MLO;
               end
               thw_pkg::MUL_CORR: begin
                  state_in = S_ROT;
               end
               thw_pkg::MUL_PX: begin
                  mid_in = thw_pkg::MUL_PY; state_in = S_MLO;
               end
               thw_pkg::MUL_PY: begin
                  state_in = S_CORD; cnt_in = 6'd0;
               end
               default: begin
                  state_in = S_DIVI; cnt_in = 6'd0;
               end
            endcase
         end
         S_ROT: begin
            cmd.op   = thw_pkg::OP_ROT;
            mid_in   = thw_pkg::MUL_PX;
            state_in = S_MLO;
         end
         S_CORD: begin
            cmd.op = thw_pkg::OP_CORD;
            if (cnt_ff == 6'(thw_pkg::TRIG_STAGES - 1)) begin
               state_in = S_ACC;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_ACC: begin
            cmd.op = thw_pkg::OP_ACC;
            if (stat.dt_gt1) begin
               mid_in   = thw_pkg::MUL_VX;
               state_in = S_MLO;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIVI: begin
            cmd.op   = thw_pkg::OP_DIVI;
            cnt_in   = 6'd0;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.op = thw_pkg::OP_DIVS;
            if (cnt_ff == 6'(thw_pkg::DIV_STEPS - 1)) begin
               state_in = S_DIVW;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_DIVW: begin
            cmd.op = thw_pkg::OP_DIVW;
            if (mid_ff == thw_pkg::MUL_VX) begin
               mid_in = thw_pkg::MUL_VY; state_in = S_MLO;
            end else if (mid_ff == thw_pkg::MUL_VY) begin
               mid_in = thw_pkg::MUL_VT; state_in = S_MLO;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.op   = thw_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[design/thw_dp.sv]
`default_nettype none
module thw_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire thw_pkg::thw_cmd_type  cmd,
   output thw_pkg::thw_stat_type      stat,
   input  wire logic [143:0]          req_tdata,
   input  wire logic                  csr_valid,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [191:0]               rsp_tdata,
   output logic [1:0]                 rsp_tuser
);

   function automatic logic signed [63:0] clamp_bits(input logic signed [63:0] v,
                                                     input int unsigned b);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< b) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   logic [31:0] mpt_ff [3];
   logic [31:0] tpm_ff;
   logic [31:0] offset_ff;

   logic [31:0]                    last_cnt_ff [3];
   logic [31:0]                    delta_ff [3];
   logic [thw_pkg::TIME_W-1:0]     last_time_ff;
   logic [thw_pkg::TIME_W-1:0]     dt_ff;
   logic                           started_ff;
   logic                           primed_ff;
   logic                           updated_ff;
   logic signed [63:0]             dist_ff [3];
   logic signed [63:0]             turn_ff, t2_ff, corr_ff, num_ff;
   logic signed [63:0]             x_ff, y_ff;
   logic signed [33:0]             z_ff;
   logic signed [thw_pkg::ACC_W-1:0] acc_x_ff, acc_y_ff;
   logic [31:0]                    head_ff;
   logic [31:0]                    held_ff [3];
   logic [47:0]                    rem_ff;
   logic [63:0]                    quo_ff;
   logic                           neg_ff;
   logic signed [65:0]             plo_ff;
   logic signed [64:0]             phi_ff;
   logic                           out_valid_ff;
   logic [191:0]                   out_data_ff;
   logic [1:0]                     out_user_ff;

   logic signed [63:0] mul_a;
   logic signed [32:0] mul_b;
   logic [5:0]         mul_sh;
   logic signed [32:0] a_lo;
   logic signed [31:0] a_hi;
   logic signed [65:0] plo;
   logic signed [64:0] phi;
   logic signed [96:0] full;
   logic signed [96:0] shifted;
   logic signed [63:0] mul_res;

   always_comb begin
      mul_a  = 64'sd0;
      mul_b  = 33'sd0;
      mul_sh = 6'd0;
      case (cmd.mid)
         thw_pkg::MUL_D0: begin
            mul_a = {{32{delta_ff[0][31]}}, delta_ff[0]};
            mul_b = {1'b0, mpt_ff[0]}; mul_sh = 6'd8;
         end
         thw_pkg::MUL_D1: begin
            mul_a = {{32{delta_ff[1][31]}}, delta_ff[1]};
            mul_b = {1'b0, mpt_ff[1]}; mul_sh = 6'd8;
         end
         thw_pkg::MUL_D2: begin
            mul_a = {{32{delta_ff[2][31]}}, delta_ff[2]};
            mul_b = {1'b0, mpt_ff[2]}; mul_sh = 6'd8;
         end
         thw_pkg::MUL_TURN: begin
            mul_a = dist_ff[0] - dist_ff[1];
            mul_b = {1'b0, tpm_ff}; mul_sh = 6'd16;
         end
         thw_pkg::MUL_T2: begin
            mul_a = turn_ff; mul_b = {1'b0, thw_pkg::TWO_PI_Q29}; mul_sh = 6'd29;
         end
         thw_pkg::MUL_CORR: begin
            mul_a = t2_ff; mul_b = {offset_ff[31], offset_ff}; mul_sh = 6'd32;
         end
         thw_pkg::MUL_PX: begin
            mul_a = x_ff; mul_b = {1'b0, thw_pkg::INV_GAIN}; mul_sh = 6'd32;
         end
         thw_pkg::MUL_PY: begin
            mul_a = y_ff; mul_b = {1'b0, thw_pkg::INV_GAIN}; mul_sh = 6'd32;
         end
         thw_pkg::MUL_VX: begin
            mul_a = x_ff; mul_b = {1'b0, thw_pkg::VEL_SCALE}; mul_sh = 6'd8;
         end
         thw_pkg::MUL_VY: begin
            mul_a = y_ff; mul_b = {1'b0, thw_pkg::VEL_SCALE}; mul_sh = 6'd8;
         end
         thw_pkg::MUL_VT: begin
            mul_a = turn_ff; mul_b = {1'b0, thw_pkg::TWO_PI_E6_Q8}; mul_sh = 6'd24;
         end
         default: begin
            mul_a = 64'sd0;
         end
      endcase
   end

   assign a_lo = {1'b0, mul_a[31:0]};
   assign a_hi = mul_a[63:32];
   assign plo  = a_lo * mul_b;
   assign phi  = a_hi * mul_b;

   always_comb begin
      full    = {phi_ff, 32'd0} + {{31{plo_ff[65]}}, plo_ff};
      shifted = full >>> mul_sh;
      if ((&shifted[96:63]) || !(|shifted[96:63])) begin
         mul_res = shifted[63:0];
      end else if (shifted[96]) begin
         mul_res = {1'b1, 63'd0};
      end else begin
         mul_res = {1'b0, {63{1'b1}}};
      end
   end

   logic signed [63:0] fwd, lat, diff2;
   logic [31:0]        ang, ang_q, ang_r;
   logic               flip;

   always_comb begin
      fwd   = clamp_bits((dist_ff[0] + dist_ff[1]) >>> 1, 47);
      diff2 = dist_ff[2] - clamp_bits(corr_ff, 56);
      lat   = clamp_bits(diff2, 47);
      ang   = head_ff + turn_ff[32:1];
      ang_q = ang + 32'h4000_0000;
      flip  = ang_q[31];
      ang_r = flip ? (ang + 32'h8000_0000) : ang;
   end

   logic signed [63:0] xs, ys;
   logic signed [33:0] atn;

   assign xs  = x_ff >>> cmd.iter;
   assign ys  = y_ff >>> cmd.iter;
   assign atn = {2'b00, thw_pkg::atan_entry(cmd.iter)};

   logic signed [63:0] ax, ay;

   assign ax = clamp_bits({{16{acc_x_ff[47]}}, acc_x_ff} + (x_ff <<< 8), 47);
   assign ay = clamp_bits({{16{acc_y_ff[47]}}, acc_y_ff} + (y_ff <<< 8), 47);

   logic [48:0] dtrial;
   logic [48:0] dsub;
   logic        dge;
   logic [31:0] vel_q;
   logic [63:0] quo_neg;
   logic [1:0]  vsel;

   always_comb begin
      dtrial  = {rem_ff, quo_ff[63]};
      dsub    = dtrial - {1'b0, dt_ff};
      dge     = (dtrial >= {1'b0, dt_ff});
      quo_neg = -quo_ff;
      if (!neg_ff) begin
         vel_q = (quo_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_ff[31:0];
      end else begin
         vel_q = (quo_ff > 64'h8000_0000) ? 32'h8000_0000 : quo_neg[31:0];
      end
      if (cmd.mid == thw_pkg::MUL_VX) begin
         vsel = 2'd0;
      end else if (cmd.mid == thw_pkg::MUL_VY) begin
         vsel = 2'd1;
      end else begin
         vsel = 2'd2;
      end
   end

   logic [31:0]               cur_cnt [3];
   logic [thw_pkg::TIME_W-1:0] now_time;

   assign cur_cnt[0] = req_tdata[31:0];
   assign cur_cnt[1] = req_tdata[63:32];
   assign cur_cnt[2] = req_tdata[95:64];
   assign now_time   = req_tdata[143:96];

   always_ff @(posedge clock) begin
      if (reset) begin
         mpt_ff[0]    <= thw_pkg::MPT_RESET;
         mpt_ff[1]    <= thw_pkg::MPT_RESET;
         mpt_ff[2]    <= thw_pkg::MPT_RESET;
         tpm_ff       <= thw_pkg::TPM_RESET;
         offset_ff    <= thw_pkg::OFFSET_RESET;
         last_cnt_ff[0] <= 32'd0;
         last_cnt_ff[1] <= 32'd0;
         last_cnt_ff[2] <= 32'd0;
         last_time_ff <= '0;
         started_ff   <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         head_ff      <= 32'd0;
         held_ff[0]   <= 32'd0;
         held_ff[1]   <= 32'd0;
         held_ff[2]   <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               thw_pkg::REG_MPT_RIGHT: mpt_ff[0] <= csr_data;
               thw_pkg::REG_MPT_LEFT:  mpt_ff[1] <= csr_data;
               thw_pkg::REG_MPT_SIDE:  mpt_ff[2] <= csr_data;
               thw_pkg::REG_TPM:       tpm_ff    <= csr_data;
               thw_pkg::REG_OFFSET:    offset_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.op == thw_pkg::OP_LOAD) begin
            for (int i = 0; i < 3; i++) begin
               last_cnt_ff[i] <= cur_cnt[i];
            end
            last_time_ff <= now_time;
            started_ff   <= 1'b1;
         end
         if (cmd.op == thw_pkg::OP_ACC) begin
            acc_x_ff <= ax[thw_pkg::ACC_W-1:0];
            acc_y_ff <= ay[thw_pkg::ACC_W-1:0];
            head_ff  <= head_ff + turn_ff[31:0];
         end
         if (cmd.op == thw_pkg::OP_DIVW) begin
            held_ff[vsel] <= vel_q;
         end
         if (cmd.op == thw_pkg::OP_OUT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         thw_pkg::OP_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               delta_ff[i] <= cur_cnt[i] - last_cnt_ff[i];
            end
            dt_ff      <= now_time - last_time_ff;
            primed_ff  <= started_ff;
            updated_ff <= 1'b0;
         end
         thw_pkg::OP_MLO: begin
            plo_ff <= plo;
         end
         thw_pkg::OP_MHI: begin
            phi_ff <= phi;
         end
         thw_pkg::OP_MWB: begin
            case (cmd.mid)
               thw_pkg::MUL_D0:   dist_ff[0] <= mul_res;
               thw_pkg::MUL_D1:   dist_ff[1] <= mul_res;
               thw_pkg::MUL_D2:   dist_ff[2] <= mul_res;
               thw_pkg::MUL_TURN: turn_ff    <= mul_res;
               thw_pkg::MUL_T2:   t2_ff      <= mul_res;
               thw_pkg::MUL_CORR: corr_ff    <= mul_res;
               thw_pkg::MUL_PX:   x_ff       <= mul_res;
               thw_pkg::MUL_PY:   y_ff       <= mul_res;
               default:           num_ff     <= mul_res;
            endcase
         end
         thw_pkg::OP_ROT: begin
            x_ff <= flip ? -fwd : fwd;
            y_ff <= flip ? -lat : lat;
            z_ff <= {{2{ang_r[31]}}, ang_r};
         end
         thw_pkg::OP_CORD: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atn;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atn;
            end
         end
         thw_pkg::OP_DIVI: begin
            neg_ff <= num_ff[63];
            quo_ff <= num_ff[63] ? -num_ff : num_ff;
            rem_ff <= 48'd0;
         end
         thw_pkg::OP_DIVS: begin
            rem_ff <= dge ? dsub[47:0] : dtrial[47:0];
            quo_ff <= {quo_ff[62:0], dge};
         end
         thw_pkg::OP_DIVW: begin
            updated_ff <= 1'b1;
         end
         thw_pkg::OP_OUT: begin
            out_data_ff <= {held_ff[2], held_ff[1], held_ff[0], head_ff,
                            acc_y_ff[47:16], acc_x_ff[47:16]};
            out_user_ff <= {updated_ff, primed_ff};
         end
         default: ;
      endcase
   end

   assign stat.started  = started_ff;
   assign stat.dt_gt1   = (dt_ff > 48'd1);
   assign stat.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
`default_nettype wire

[design/three_wheel_odometry_top.sv]
// Three-wheel odometry: integrates right, left and side encoder counts into a pose.
// The req channel carries one sample per beat: three absolute counts and a timestamp
// in microseconds. The rsp channel returns one beat per sample with position, heading,
// held velocities, and flags for the baseline sample and for a velocity update.
// The csr channel writes the wheel scale, turn factor and side offset; it is always
// ready. The user must write it only while no sample is in flight; the block does
// not enforce this. One sample is processed at a time by a state machine over a
// shared 33x33 multiplier, an iterative rotator and a one-bit-per-cycle divider. The
// first sample after reset only sets the baseline. Later samples run eight multiplies
// (low product, high product, writeback), the rotator stages and the accumulate step,
// and, if velocities are recomputed, three more multiplies and three 64-step divisions
// by the sample interval. req_tready stays low until the response is loaded. The
// response sits in an output register; while the receiver stalls, the block can
// accept and process the next sample and then waits to load its response. Reset is
// synchronous; it clears pose, velocities and baseline and resets the csr registers.
`default_nettype none
module three_wheel_odometry_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // right_count, left_count, side_count, time_us
   input  wire logic [143:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x, pos_y, heading, vel_x, vel_y, turn_rate
   output logic [191:0]      rsp_tdata,
   // primed, velocity_updated
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   thw_pkg::thw_cmd_type  cmd;
   thw_pkg::thw_stat_type stat;

   assign csr_ready = 1'b1;

   thw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   thw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[design/thw_checker.sv]
`default_nettype none
module thw_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [191:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted while another is in flight");

   a_baseline_no_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("baseline sample reported a velocity update");

endmodule

bind three_wheel_odometry_top thw_checker u_thw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[tb/three_wheel_odometry_top_tb.sv]
`timescale 1ns / 1ps
module three_wheel_odometry_top_tb;

   localparam logic [2:0] REG_SPARE = 3'd7;

   typedef struct {
      logic [31:0] right_count;
      logic [31:0] left_count;
      logic [31:0] side_count;
      logic [47:0] time_us;
   } sample_type;

   typedef struct {
      logic [191:0] data;
      logic [1:0]   user;
   } pose_type;

   class pose_scoreboard;
      logic [31:0] mpt [3];
      logic [31:0] tpm;
      logic [31:0] offs;
      logic [31:0] last_cnt [3];
      logic [47:0] last_time;
      bit started;
      logic signed [63:0] ax, ay;
      logic [31:0] hd;
      logic signed [63:0] hv [3];
      pose_type pending_poses [$];
      int fails;

      function new();
         mpt = '{thw_pkg::MPT_RESET, thw_pkg::MPT_RESET, thw_pkg::MPT_RESET};
         tpm = thw_pkg::TPM_RESET;
         offs = thw_pkg::OFFSET_RESET;
         last_cnt = '{0, 0, 0};
         last_time = 0;
         started = 0;
         ax = 0;
         ay = 0;
         hd = 0;
         hv = '{0, 0, 0};
         fails = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            thw_pkg::REG_MPT_RIGHT: mpt[0] = val;
            thw_pkg::REG_MPT_LEFT:  mpt[1] = val;
            thw_pkg::REG_MPT_SIDE:  mpt[2] = val;
            thw_pkg::REG_TPM:       tpm = val;
            thw_pkg::REG_OFFSET:    offs = val;
            default: ;
         endcase
      endfunction

      function logic signed [63:0] scale(logic signed [63:0] a, logic signed [63:0] b,
                                         int sh);
         logic signed [127:0] p, q;
         p = a;
         q = b;
         p = (p * q) >>> sh;
         if (p > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
         if (p < -128'sh8000000000000000) return 64'sh8000000000000000;
         return p[63:0];
      endfunction

      function logic signed [63:0] clip(logic signed [63:0] v, int b);
         logic signed [63:0] hi;
         hi = (64'sd1 <<< b) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      function logic signed [63:0] rate(logic signed [63:0] num, logic [47:0] dt);
         logic [63:0] mag, q;
         mag = num < 0 ? -num : num;
         q = mag / {16'd0, dt};
         if (num >= 0) return q > 64'h7FFFFFFF ? 64'sh7FFFFFFF : $signed(q);
         return q > 64'h80000000 ? -64'sh80000000 : -$signed(q);
      endfunction

      function void rotate(inout logic signed [63:0] x, inout logic signed [63:0] y,
                           input logic [31:0] ang);
         logic [31:0] arc [24];
         logic signed [63:0] z, nx, ny;
         arc = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
         if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
            x = -x;
            y = -y;
            ang = ang + 32'h80000000;
         end
         z = $signed(ang);
         x = scale(x, {32'd0, thw_pkg::INV_GAIN}, 32);
         y = scale(y, {32'd0, thw_pkg::INV_GAIN}, 32);
         for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               ny = y + (x >>> i);
               z = z - arc[i];
            end else begin
               nx = x + (y >>> i);
               ny = y - (x >>> i);
               z = z + arc[i];
            end
            x = nx;
            y = ny;
         end
      endfunction

      function void note_sample(sample_type s);
         logic [31:0] cur [3];
         logic signed [31:0] delta;
         logic signed [63:0] wheel_dist [3];
         logic signed [63:0] fwd, lat, turn, corr, dx, dy;
         logic [47:0] dt;
         bit primed, updated;
         pose_type p;
         cur = '{s.right_count, s.left_count, s.side_count};
         primed = started;
         updated = 0;
         if (!started) begin
            last_cnt = cur;
            last_time = s.time_us;
            started = 1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               delta = cur[i] - last_cnt[i];
               last_cnt[i] = cur[i];
               wheel_dist[i] = clip(scale(64'(delta), {32'd0, mpt[i]}, 8), 56);
            end
            fwd = clip((wheel_dist[0] + wheel_dist[1]) >>> 1, 47);
            turn = scale(wheel_dist[0] - wheel_dist[1], {32'd0, tpm}, 16);
            corr = scale(64'($signed(offs)),
                         scale(turn, {32'd0, thw_pkg::TWO_PI_Q29}, 29), 32);
            lat = clip(wheel_dist[2] - clip(corr, 56), 47);
            dx = fwd;
            dy = lat;
            rotate(dx, dy, hd + 32'(turn >>> 1));
            ax = clip(ax + dx * 256, 47);
            ay = clip(ay + dy * 256, 47);
            hd = hd + turn[31:0];
            dt = s.time_us - last_time;
            last_time = s.time_us;
            if (dt > 1) begin
               hv[0] = rate(scale(dx, 64'd1000000, 8), dt);
               hv[1] = rate(scale(dy, 64'd1000000, 8), dt);
               hv[2] = rate(scale(turn, {32'd0, thw_pkg::TWO_PI_E6_Q8}, 24), dt);
               updated = 1;
            end
         end
         p.data = {hv[2][31:0], hv[1][31:0], hv[0][31:0], hd,
                   32'(ay >>> 16), 32'(ax >>> 16)};
         p.user = {updated, primed};
         pending_poses.push_back(p);
      endfunction

      function void check_pose(logic [191:0] data, logic [1:0] user);
         pose_type p;
         if (pending_poses.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected response beat %h/%b", data, user);
            return;
         end
         p = pending_poses.pop_front();
         for (int f = 0; f < 6; f++) begin
            if (data[f*32 +: 32] !== p.data[f*32 +: 32]) begin
               fails++;
               if (fails <= 10)
                  $display("field %0d: expected %h, got %h", f,
                           p.data[f*32 +: 32], data[f*32 +: 32]);
            end
         end
         if (user !== p.user) begin
            fails++;
            if (fails <= 10) $display("flags: expected %b, got %b", p.user, user);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pose_scoreboard sb = new();
   logic [31:0] rc, lc, sc;
   logic [47:0] now_us;
   int stall_left = 0;
   bit calm = 0;

   three_wheel_odometry_top uut (.*);

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 300);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_pose(rsp_tdata, rsp_tuser);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            stall_left <= pick_gap();
         end
      end
   end

   task automatic send(logic [31:0] r, logic [31:0] l, logic [31:0] s, logic [47:0] t);
      sample_type smp;
      int gap;
      smp = '{r, l, s, t};
      gap = pick_gap();
      req_tvalid <= 1;
      req_tdata <= {t, s, l, r};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(smp);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_poses.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic walk(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (k % 60 == 0) calm = $urandom_range(0, 2) == 0;
         if (r < 78) begin
            rc = rc + $signed(32'($urandom_range(0, 4000)) - 2000);
            lc = lc + $signed(32'($urandom_range(0, 4000)) - 2000);
            sc = sc + $signed(32'($urandom_range(0, 4000)) - 2000);
            now_us = now_us + $urandom_range(2, 20000);
         end else if (r < 88) begin
            rc = rc + $urandom_range(0, 50);
            now_us = now_us + $urandom_range(0, 1);
         end else begin
            rc = $urandom;
            lc = $urandom;
            sc = $urandom;
            now_us = {16'($urandom), 32'($urandom)};
         end
         send(rc, lc, sc, now_us);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(32'd100, 32'd200, 32'd300, 48'd5000);
      send(32'd1100, 32'd1200, 32'd300, 48'd15000);
      send(32'd1100, 32'd1200, 32'd300, 48'd15000);
      send(32'd1500, 32'd900, 32'd700, 48'd15001);
      send(32'd1600, 32'd800, 32'd700, 48'd15003);
      send(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 48'd25000);
      send(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 48'd35000);
      send(32'hFFFFFFFF, 32'h00000000, 32'h00000001, 48'hFFFFFFFFFFFF);
      send(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'd10);
      send(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'd5);
      send(32'h40000000, 32'hC0000000, 32'h0, 48'd100005);
      send(32'h0, 32'h0, 32'h0, 48'h800000000000);
      drain();

      write_csr(thw_pkg::REG_MPT_RIGHT, 32'hFFFFFFFF);
      write_csr(thw_pkg::REG_MPT_LEFT, 32'hFFFFFFFF);
      write_csr(thw_pkg::REG_MPT_SIDE, 32'hFFFFFFFF);
      write_csr(thw_pkg::REG_TPM, 32'hFFFFFFFF);
      write_csr(thw_pkg::REG_OFFSET, 32'h80000000);
      send(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 48'd200000);
      send(32'h0, 32'h0, 32'h80000000, 48'd210000);
      send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'd220000);
      send(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'd220001);
      rc = 0;
      lc = 0;
      sc = 0;
      now_us = 48'd300000;
      walk(160);
      drain();

      write_csr(thw_pkg::REG_MPT_RIGHT, 32'h0);
      write_csr(thw_pkg::REG_MPT_LEFT, 32'h0);
      write_csr(thw_pkg::REG_MPT_SIDE, 32'h0);
      write_csr(thw_pkg::REG_TPM, 32'h0);
      write_csr(thw_pkg::REG_OFFSET, 32'h7FFFFFFF);
      write_csr(REG_SPARE, 32'h12345678);
      walk(100);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         write_csr(thw_pkg::REG_MPT_RIGHT, $urandom_range(50000, 2000000));
         write_csr(thw_pkg::REG_MPT_LEFT, $urandom_range(50000, 2000000));
         write_csr(thw_pkg::REG_MPT_SIDE, $urandom);
         write_csr(thw_pkg::REG_TPM, $urandom);
         write_csr(thw_pkg::REG_OFFSET, $urandom);
         walk(140);
         drain();
      end

      write_csr(thw_pkg::REG_MPT_RIGHT, thw_pkg::MPT_RESET);
      write_csr(thw_pkg::REG_MPT_LEFT, thw_pkg::MPT_RESET);
      write_csr(thw_pkg::REG_MPT_SIDE, thw_pkg::MPT_RESET);
      write_csr(thw_pkg::REG_TPM, thw_pkg::TPM_RESET);
      write_csr(thw_pkg::REG_OFFSET, thw_pkg::OFFSET_RESET);
      walk(150);
      drain();

      if (sb.fails == 0) begin
         $display("** three_wheel_odometry_top: PASSED **");
      end else begin
         $display("** three_wheel_odometry_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("** three_wheel_odometry_top: FAILED **");
      $finish;
   end

endmodule
